>>> rtl/image_aspect_fit_scaler_assert.svh
// Assertion macros for the aspect-fit scaler checker.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef IMAGE_ASPECT_FIT_SCALER_ASSERT_SVH
`define IMAGE_ASPECT_FIT_SCALER_ASSERT_SVH

// same-cycle implication
`define AIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aif_pkg.sv
// Shared types, constants and helpers for the aspect-fit scaler.
// No dependencies; used by every other file of the block but the assertion header.
`default_nettype none
package aif_pkg;

  localparam int MAX_SRC_SIDE = 64;
  localparam int MAX_BOX_SIDE = 1023;

  localparam int SRC_W   = 7;
  localparam int BOX_W   = 10;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int ALPHA_W = 8;
  localparam int ADDR_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_W  = SRC_W + BOX_W;
  localparam int DD_W   = 16;
  localparam int QUO_W  = BOX_W;
  localparam int NB_W   = 4;
  localparam int DSH_W  = BOX_W + QUO_W - 1;

  localparam logic [NB_W-1:0] FIT_QBITS    = NB_W'(QUO_W);
  localparam logic [NB_W-1:0] SAMPLE_QBITS = NB_W'(SRC_W);

  localparam logic [ALPHA_W-1:0] ALPHA_MIN_VISIBLE = ALPHA_W'(8);
  localparam logic [ALPHA_W-1:0] ALPHA_MIN_OPAQUE  = ALPHA_W'(250);
  localparam logic [ALPHA_W-1:0] ALPHA_FULL        = ALPHA_W'(255);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_BOX_WIDTH  = 3'd2,
    CFG_BOX_HEIGHT = 3'd3,
    CFG_ORIGIN_X   = 3'd4,
    CFG_ORIGIN_Y   = 3'd5,
    CFG_ALPHA_PRES = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT_A,
    ST_FIT_B,
    ST_FIT_C,
    ST_FIT_DIV,
    ST_FIT_OFF,
    ST_COL_MUL,
    ST_COL_DIV,
    ST_COL_WAIT,
    ST_ROW_MUL,
    ST_ROW_DIV,
    ST_ROW_WAIT,
    ST_IDX_MUL,
    ST_IDX_ADD,
    ST_READ
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  load_index;
    logic [COLOR_W-1:0] load_color;
    logic [ALPHA_W-1:0] load_alpha;
  } in_item_t;

  typedef struct packed {
    logic                      visible;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [COLOR_W-1:0]        color;
    logic [ALPHA_W-1:0]        alpha;
    logic                      opaque;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DD_W-1:0]  dividend;
    logic [BOX_W-1:0] divisor;
    logic [NB_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
    logic [SRC_W-1:0] r;
    r = v;
    if (v == '0) r = SRC_W'(1);
    else if (v > SRC_W'(MAX_SRC_SIDE)) r = SRC_W'(MAX_SRC_SIDE);
    return r;
  endfunction

  function automatic logic [BOX_W-1:0] clamp_box(input logic [BOX_W-1:0] v);
    logic [BOX_W-1:0] r;
    r = v;
    if (v == '0) r = BOX_W'(1);
    else if (v > BOX_W'(MAX_BOX_SIDE)) r = BOX_W'(MAX_BOX_SIDE);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/image_aspect_fit_scaler.sv
// Aspect-fit nearest-neighbour scaler: a load word is written to the store and busy stays low.
// Draw word: column and row divides, index multiply-add, store read, then the out_valid strobe.
// The first draw after reset or a config write first computes the fit (10-bit divide).
// A new start is taken in the cycle the result strobe shows; results cannot be stalled.
// Reset (rst_n low, synchronous) restores register defaults and restarts the walk.
// Depends on aif_pkg, aif_div, aif_store.
`default_nettype none
module image_aspect_fit_scaler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire aif_pkg::in_item_t              in_data,
  output logic                                out_valid,
  output aif_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [aif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aif_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = aif_pkg::SRC_W;
  localparam int BW = aif_pkg::BOX_W;
  localparam int CW = aif_pkg::COORD_W;
  localparam int AW = aif_pkg::ADDR_W;

  aif_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]        src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [BW-1:0]        box_w_r, box_w_nxt, box_h_r, box_h_nxt;
  logic signed [CW-1:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic                 alpha_pres_r, alpha_pres_nxt;

  logic [BW-1:0]        col_r, col_nxt, row_r, row_nxt;
  logic                 fit_ok_r, fit_ok_nxt;
  logic                 fit_w_r, fit_w_nxt;
  logic [BW-1:0]        fw_r, fw_nxt, fh_r, fh_nxt;
  logic signed [CW-1:0] off_x_r, off_x_nxt, off_y_r, off_y_nxt;
  logic [aif_pkg::MUL_W-1:0] p1_r, p1_nxt, mul_p_r, mul_p_nxt;
  logic [SW-1:0]        sx_r, sx_nxt, sy_r, sy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  aif_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [SW-1:0]        sw, sh;
  logic [BW-1:0]        bw, bh;
  logic [BW-1:0]        mul_a;
  logic [SW-1:0]        mul_b;
  logic [BW-1:0]        q_fit;
  logic [aif_pkg::ALPHA_W-1:0] alpha_v;
  logic                 col_end, row_end;

  aif_pkg::div_req_t div_req;
  aif_pkg::div_rsp_t div_rsp;

  logic                        wr_en, rd_en;
  logic [AW-1:0]               rd_addr;
  logic [aif_pkg::COLOR_W-1:0] rd_color;
  logic [aif_pkg::ALPHA_W-1:0] rd_alpha;

  aif_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  aif_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (in_data.load_index),
    .wr_color (in_data.load_color),
    .wr_alpha (in_data.load_alpha),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_color (rd_color),
    .rd_alpha (rd_alpha)
  );

  assign sw = aif_pkg::clamp_src(src_w_r);
  assign sh = aif_pkg::clamp_src(src_h_r);
  assign bw = aif_pkg::clamp_box(box_w_r);
  assign bh = aif_pkg::clamp_box(box_h_r);

  assign busy      = (state_r != aif_pkg::ST_IDLE);
  assign cfg_ready = (state_r == aif_pkg::ST_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mul_p_nxt = {{SW{1'b0}}, mul_a} * {{BW{1'b0}}, mul_b};
  assign q_fit     = (div_rsp.quotient == '0) ? BW'(1) : div_rsp.quotient;
  assign alpha_v   = alpha_pres_r ? rd_alpha : aif_pkg::ALPHA_FULL;
  assign col_end   = (BW'(col_r + BW'(1)) == fw_r);
  assign row_end   = (BW'(row_r + BW'(1)) == fh_r);

  always_comb begin
    state_nxt      = state_r;
    src_w_nxt      = src_w_r;
    src_h_nxt      = src_h_r;
    box_w_nxt      = box_w_r;
    box_h_nxt      = box_h_r;
    org_x_nxt      = org_x_r;
    org_y_nxt      = org_y_r;
    alpha_pres_nxt = alpha_pres_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    fit_ok_nxt     = fit_ok_r;
    fit_w_nxt      = fit_w_r;
    fw_nxt         = fw_r;
    fh_nxt         = fh_r;
    off_x_nxt      = off_x_r;
    off_y_nxt      = off_y_r;
    p1_nxt         = p1_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    mul_a          = col_r;
    mul_b          = sw;
    div_req        = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state_r)
      aif_pkg::ST_IDLE: begin
        if (start) begin
          if (in_data.kind == aif_pkg::KIND_LOAD) begin
            wr_en = 1'b1;
          end else if (fit_ok_r) begin
            state_nxt = aif_pkg::ST_COL_MUL;
          end else begin
            state_nxt = aif_pkg::ST_FIT_A;
          end
        end
      end
      aif_pkg::ST_FIT_A: begin
        mul_a     = bh;
        mul_b     = sw;
        state_nxt = aif_pkg::ST_FIT_B;
      end
      aif_pkg::ST_FIT_B: begin
        p1_nxt    = mul_p_r;
        mul_a     = bw;
        mul_b     = sh;
        state_nxt = aif_pkg::ST_FIT_C;
      end
      aif_pkg::ST_FIT_C: begin
        if (p1_r < mul_p_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = p1_r[aif_pkg::DD_W-1:0];
          div_req.divisor  = {{(BW-SW){1'b0}}, sh};
          div_req.nbits    = aif_pkg::FIT_QBITS;
          fit_w_nxt        = 1'b1;
          state_nxt        = aif_pkg::ST_FIT_DIV;
        end else if (mul_p_r < p1_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_p_r[aif_pkg::DD_W-1:0];
          div_req.divisor  = {{(BW-SW){1'b0}}, sw};
          div_req.nbits    = aif_pkg::FIT_QBITS;
          fit_w_nxt        = 1'b0;
          state_nxt        = aif_pkg::ST_FIT_DIV;
        end else begin
          fw_nxt    = bw;
          fh_nxt    = bh;
          state_nxt = aif_pkg::ST_FIT_OFF;
        end
      end
      aif_pkg::ST_FIT_DIV: begin
        if (div_rsp.done) begin
          fw_nxt    = fit_w_r ? q_fit : bw;
          fh_nxt    = fit_w_r ? bh : q_fit;
          state_nxt = aif_pkg::ST_FIT_OFF;
        end
      end
      aif_pkg::ST_FIT_OFF: begin
        off_x_nxt  = org_x_r + CW'((bw - fw_r) >> 1);
        off_y_nxt  = org_y_r + CW'((bh - fh_r) >> 1);
        fit_ok_nxt = 1'b1;
        if (col_r >= fw_r || row_r >= fh_r) begin
          col_nxt = '0;
          row_nxt = '0;
        end
        state_nxt = aif_pkg::ST_COL_MUL;
      end
      aif_pkg::ST_COL_MUL: begin
        mul_a     = col_r;
        mul_b     = sw;
        state_nxt = aif_pkg::ST_COL_DIV;
      end
      aif_pkg::ST_COL_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p_r[aif_pkg::DD_W-1:0];
        div_req.divisor  = fw_r;
        div_req.nbits    = aif_pkg::SAMPLE_QBITS;
        state_nxt        = aif_pkg::ST_COL_WAIT;
      end
      aif_pkg::ST_COL_WAIT: begin
        if (div_rsp.done) begin
          sx_nxt    = div_rsp.quotient[SW-1:0];
          state_nxt = aif_pkg::ST_ROW_MUL;
        end
      end
      aif_pkg::ST_ROW_MUL: begin
        mul_a     = row_r;
        mul_b     = sh;
        state_nxt = aif_pkg::ST_ROW_DIV;
      end
      aif_pkg::ST_ROW_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p_r[aif_pkg::DD_W-1:0];
        div_req.divisor  = fh_r;
        div_req.nbits    = aif_pkg::SAMPLE_QBITS;
        state_nxt        = aif_pkg::ST_ROW_WAIT;
      end
      aif_pkg::ST_ROW_WAIT: begin
        if (div_rsp.done) begin
          sy_nxt    = div_rsp.quotient[SW-1:0];
          state_nxt = aif_pkg::ST_IDX_MUL;
        end
      end
      aif_pkg::ST_IDX_MUL: begin
        mul_a     = {{(BW-SW){1'b0}}, sy_r};
        mul_b     = sw;
        state_nxt = aif_pkg::ST_IDX_ADD;
      end
      aif_pkg::ST_IDX_ADD: begin
        rd_en     = 1'b1;
        rd_addr   = mul_p_r[AW-1:0] + {{(AW-SW){1'b0}}, sx_r};
        state_nxt = aif_pkg::ST_READ;
      end
      aif_pkg::ST_READ: begin
        out_valid_nxt        = 1'b1;
        out_data_nxt.visible = (alpha_v >= aif_pkg::ALPHA_MIN_VISIBLE);
        out_data_nxt.dest_x  = off_x_r + CW'(col_r);
        out_data_nxt.dest_y  = off_y_r + CW'(row_r);
        out_data_nxt.color   = rd_color;
        out_data_nxt.alpha   = alpha_v;
        out_data_nxt.opaque  = (alpha_v >= aif_pkg::ALPHA_MIN_OPAQUE);
        out_data_nxt.last    = col_end && row_end;
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_end ? '0 : BW'(row_r + BW'(1));
        end else begin
          col_nxt = BW'(col_r + BW'(1));
        end
        state_nxt = aif_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = aif_pkg::ST_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      col_nxt    = '0;
      row_nxt    = '0;
      fit_ok_nxt = 1'b0;
      case (cfg_index)
        aif_pkg::CFG_SRC_WIDTH:  src_w_nxt      = cfg_data[SW-1:0];
        aif_pkg::CFG_SRC_HEIGHT: src_h_nxt      = cfg_data[SW-1:0];
        aif_pkg::CFG_BOX_WIDTH:  box_w_nxt      = cfg_data[BW-1:0];
        aif_pkg::CFG_BOX_HEIGHT: box_h_nxt      = cfg_data[BW-1:0];
        aif_pkg::CFG_ORIGIN_X:   org_x_nxt      = cfg_data[CW-1:0];
        aif_pkg::CFG_ORIGIN_Y:   org_y_nxt      = cfg_data[CW-1:0];
        aif_pkg::CFG_ALPHA_PRES: alpha_pres_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aif_pkg::ST_IDLE;
      src_w_r      <= SW'(1);
      src_h_r      <= SW'(1);
      box_w_r      <= BW'(1);
      box_h_r      <= BW'(1);
      org_x_r      <= '0;
      org_y_r      <= '0;
      alpha_pres_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      fit_ok_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      src_w_r      <= src_w_nxt;
      src_h_r      <= src_h_nxt;
      box_w_r      <= box_w_nxt;
      box_h_r      <= box_h_nxt;
      org_x_r      <= org_x_nxt;
      org_y_r      <= org_y_nxt;
      alpha_pres_r <= alpha_pres_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      fit_ok_r     <= fit_ok_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fit_w_r    <= fit_w_nxt;
    fw_r       <= fw_nxt;
    fh_r       <= fh_nxt;
    off_x_r    <= off_x_nxt;
    off_y_r    <= off_y_nxt;
    p1_r       <= p1_nxt;
    mul_p_r    <= mul_p_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/aif_div.sv
// Shared restoring divider, one quotient bit per cycle, quotient width set per request.
// Depends on aif_pkg.
`default_nettype none
module aif_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aif_pkg::div_req_t req,
  output aif_pkg::div_rsp_t      rsp
);

  logic [aif_pkg::DD_W-1:0]  rem_r, rem_nxt;
  logic [aif_pkg::DSH_W-1:0] dsh_r, dsh_nxt;
  logic [aif_pkg::QUO_W-1:0] q_r, q_nxt;
  logic [aif_pkg::NB_W-1:0]  cnt_r, cnt_nxt;
  logic                      act_r, act_nxt;
  logic                      done_r, done_nxt;
  logic                      ge;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    act_nxt  = act_r;
    done_nxt = 1'b0;
    ge = {{(aif_pkg::DSH_W-aif_pkg::DD_W){1'b0}}, rem_r} >= dsh_r;
    if (req.start) begin
      rem_nxt = req.dividend;
      dsh_nxt = {{(aif_pkg::DSH_W-aif_pkg::BOX_W){1'b0}}, req.divisor}
                << (req.nbits - aif_pkg::NB_W'(1));
      q_nxt   = '0;
      cnt_nxt = req.nbits;
      act_nxt = 1'b1;
    end else if (act_r) begin
      if (ge) begin
        rem_nxt = aif_pkg::DD_W'({{(aif_pkg::DSH_W-aif_pkg::DD_W){1'b0}}, rem_r} - dsh_r);
      end
      q_nxt    = {q_r[aif_pkg::QUO_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - aif_pkg::NB_W'(1);
      act_nxt  = (cnt_r != aif_pkg::NB_W'(1));
      done_nxt = (cnt_r == aif_pkg::NB_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule
`default_nettype wire

>>> rtl/aif_store.sv
// Source image store: colour and alpha memories, one write and one registered read port.
// Depends on aif_pkg.
`default_nettype none
module aif_store (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [aif_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [aif_pkg::COLOR_W-1:0] wr_color,
  input  wire logic [aif_pkg::ALPHA_W-1:0] wr_alpha,
  input  wire logic                        rd_en,
  input  wire logic [aif_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [aif_pkg::COLOR_W-1:0] rd_color,
  output logic      [aif_pkg::ALPHA_W-1:0] rd_alpha
);

  localparam int DEPTH = 1 << aif_pkg::ADDR_W;

  logic [aif_pkg::COLOR_W-1:0] color_mem [DEPTH];
  logic [aif_pkg::ALPHA_W-1:0] alpha_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      color_mem[wr_addr] <= wr_color;
      alpha_mem[wr_addr] <= wr_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_color <= color_mem[rd_addr];
      rd_alpha <= alpha_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/aif_checker.sv
// Port-level checker for the aspect-fit scaler, bound to the top level.
// Depends on aif_pkg and image_aspect_fit_scaler_assert.svh.
`default_nettype none
`include "image_aspect_fit_scaler_assert.svh"
module aif_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire aif_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire aif_pkg::out_item_t out_data,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  logic load_acc, draw_acc, cfg_acc;

  assign load_acc = start && !busy && (in_data.kind == aif_pkg::KIND_LOAD);
  assign draw_acc = start && !busy && (in_data.kind == aif_pkg::KIND_DRAW);
  assign cfg_acc  = cfg_valid && cfg_ready;

  `AIF_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `AIF_ASSERT_NEXT(a_load_no_result, load_acc, !out_valid, "load word produced a result")
  `AIF_ASSERT_NEXT(a_draw_busy, draw_acc, busy && !cfg_ready, "draw word did not hold busy")
  `AIF_ASSERT_NEXT(a_cfg_quiet, cfg_acc, !busy && !out_valid, "config write disturbed the block")
  `AIF_ASSERT_NOW(a_opaque_visible, out_valid, out_data.visible || !out_data.opaque, "opaque but invisible")

endmodule

bind image_aspect_fit_scaler aif_checker u_aif_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

>>> test/image_aspect_fit_scaler_tb.sv
// Testbench for image_aspect_fit_scaler: loads source pixels, walks the fitted copy,
// and checks every output word against a cycle-free predictor of the aspect-fit walk.
// Depends on aif_pkg and the image_aspect_fit_scaler RTL.
module image_aspect_fit_scaler_tb;
  import aif_pkg::*;

  localparam int ITEM_TARGET  = 1400;
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_LIMIT  = 2000;
  localparam int STORE_DEPTH  = 2 ** ADDR_W;
  localparam int MAX_PRINTS   = 100;
  localparam int unsigned SRC_AREA_CAP = 256;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = '1;

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_PACE} action_e;

  typedef struct packed {
    action_e                act;
    in_item_t               word;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_val;
    logic [6:0]             idle_pct;
  } stim_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stim_step_t stim_q[$];
  out_item_t pixel_q[$];
  int unsigned errors = 0;
  int unsigned drain_count = 0;
  int unsigned stall_cycles = 0;
  logic [6:0] send_idle_pct = '0;

  // predictor state
  logic [COLOR_W-1:0] src_color [STORE_DEPTH];
  logic [ALPHA_W-1:0] src_alpha [STORE_DEPTH];
  logic [SRC_W-1:0] r_src_w, r_src_h;
  logic [BOX_W-1:0] r_box_w, r_box_h;
  logic [COORD_W-1:0] r_origin_x, r_origin_y;
  logic r_alpha_en;
  int unsigned walk_col, walk_row;

  // stimulus planning state
  bit loaded_map [STORE_DEPTH];
  int unsigned plan_sw = 1;
  int unsigned plan_sh = 1;
  int unsigned planned_words = 0;

  image_aspect_fit_scaler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned side_limit(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (cfg_idx_t'(idx))
      CFG_SRC_WIDTH:  r_src_w = val[SRC_W-1:0];
      CFG_SRC_HEIGHT: r_src_h = val[SRC_W-1:0];
      CFG_BOX_WIDTH:  r_box_w = val[BOX_W-1:0];
      CFG_BOX_HEIGHT: r_box_h = val[BOX_W-1:0];
      CFG_ORIGIN_X:   r_origin_x = val[COORD_W-1:0];
      CFG_ORIGIN_Y:   r_origin_y = val[COORD_W-1:0];
      CFG_ALPHA_PRES: r_alpha_en = val[0];
      default: ;
    endcase
    walk_col = 0;
    walk_row = 0;
  endtask

  function automatic out_item_t next_pixel();
    int unsigned sw, sh, bw, bh, fw, fh, sx, sy, a, dx, dy;
    logic [ADDR_W-1:0] addr;
    out_item_t px;
    sw = side_limit(r_src_w, MAX_SRC_SIDE);
    sh = side_limit(r_src_h, MAX_SRC_SIDE);
    bw = side_limit(r_box_w, MAX_BOX_SIDE);
    bh = side_limit(r_box_h, MAX_BOX_SIDE);
    fw = bw;
    fh = bh;
    if (sw * bh < sh * bw) begin
      fw = (sw * bh) / sh;
      if (fw == 0) fw = 1;
    end else if (sh * bw < sw * bh) begin
      fh = (sh * bw) / sw;
      if (fh == 0) fh = 1;
    end
    if (walk_col >= fw || walk_row >= fh) begin
      walk_col = 0;
      walk_row = 0;
    end
    sx = (walk_col * sw) / fw;
    sy = (walk_row * sh) / fh;
    addr = ADDR_W'(sy * sw + sx);
    a = r_alpha_en ? int'(src_alpha[addr]) : int'(ALPHA_FULL);
    dx = r_origin_x + (bw - fw) / 2 + walk_col;
    dy = r_origin_y + (bh - fh) / 2 + walk_row;
    px.visible = (a >= ALPHA_MIN_VISIBLE);
    px.dest_x  = COORD_W'(dx);
    px.dest_y  = COORD_W'(dy);
    px.color   = src_color[addr];
    px.alpha   = ALPHA_W'(a);
    px.opaque  = (a >= ALPHA_MIN_OPAQUE);
    px.last    = (walk_col + 1 == fw) && (walk_row + 1 == fh);
    walk_col++;
    if (walk_col >= fw) begin
      walk_col = 0;
      walk_row++;
      if (walk_row >= fh) walk_row = 0;
    end
    return px;
  endfunction

  // check results, then track config writes and accepted words
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      r_src_w = SRC_W'(1);
      r_src_h = SRC_W'(1);
      r_box_w = BOX_W'(1);
      r_box_h = BOX_W'(1);
      r_origin_x = '0;
      r_origin_y = '0;
      r_alpha_en = 1'b0;
      walk_col = 0;
      walk_row = 0;
    end else begin
      if (out_valid) begin
        if (pixel_q.size() == 0) begin
          flag_mismatch("unexpected result", 1, 0);
        end else begin
          want = pixel_q.pop_front();
          if (out_data.visible !== want.visible)
            flag_mismatch("visible", out_data.visible, want.visible);
          if (out_data.dest_x !== want.dest_x)
            flag_mismatch("dest_x", out_data.dest_x, want.dest_x);
          if (out_data.dest_y !== want.dest_y)
            flag_mismatch("dest_y", out_data.dest_y, want.dest_y);
          if (out_data.color !== want.color)
            flag_mismatch("color", out_data.color, want.color);
          if (out_data.alpha !== want.alpha)
            flag_mismatch("alpha", out_data.alpha, want.alpha);
          if (out_data.opaque !== want.opaque)
            flag_mismatch("opaque", out_data.opaque, want.opaque);
          if (out_data.last !== want.last)
            flag_mismatch("last", out_data.last, want.last);
        end
      end
      if (cfg_valid && cfg_ready) set_register(cfg_index, cfg_data);
      if (start && !busy) begin
        if (in_data.kind == KIND_LOAD) begin
          src_color[in_data.load_index] = in_data.load_color;
          src_alpha[in_data.load_index] = in_data.load_alpha;
        end else begin
          pixel_q.push_back(next_pixel());
        end
      end
    end
  end

  // driver: hold a word until taken, write config only once the block has drained
  always @(posedge clk) begin
    logic go_word, go_cfg;
    stim_step_t head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      drain_count <= 0;
    end else begin
      go_word = start && busy;
      go_cfg = cfg_valid && !cfg_ready;
      if ((start && !busy) || (cfg_valid && cfg_ready)) void'(stim_q.pop_front());
      if (busy || out_valid || start || pixel_q.size() != 0)
        drain_count <= 0;
      else if (drain_count < DRAIN_CYCLES)
        drain_count <= drain_count + 1;
      if (!go_word && !go_cfg && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.act)
          ACT_PACE: begin
            send_idle_pct <= head.idle_pct;
            void'(stim_q.pop_front());
          end
          ACT_WORD: begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              go_word = 1'b1;
              in_data <= head.word;
            end
          end
          ACT_CFG: begin
            if (drain_count >= DRAIN_CYCLES) begin
              go_cfg = 1'b1;
              cfg_index <= head.cfg_idx;
              cfg_data <= head.cfg_val;
            end
          end
          default: ;
        endcase
      end
      start <= go_word;
      cfg_valid <= go_cfg;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL image_aspect_fit_scaler");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_pace(input logic [6:0] pct);
    stim_step_t s;
    s = '0;
    s.act = ACT_PACE;
    s.idle_pct = pct;
    stim_q.push_back(s);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    stim_step_t s;
    s = '0;
    s.act = ACT_CFG;
    s.cfg_idx = idx;
    s.cfg_val = val;
    stim_q.push_back(s);
    if (idx == CFG_SRC_WIDTH) plan_sw = side_limit(val[SRC_W-1:0], MAX_SRC_SIDE);
    if (idx == CFG_SRC_HEIGHT) plan_sh = side_limit(val[SRC_W-1:0], MAX_SRC_SIDE);
  endtask

  task automatic push_load(input int unsigned idx, input logic [COLOR_W-1:0] color,
                           input logic [ALPHA_W-1:0] alpha);
    stim_step_t s;
    s = '0;
    s.act = ACT_WORD;
    s.word.kind = KIND_LOAD;
    s.word.load_index = ADDR_W'(idx);
    s.word.load_color = color;
    s.word.load_alpha = alpha;
    stim_q.push_back(s);
    loaded_map[ADDR_W'(idx)] = 1'b1;
    planned_words++;
  endtask

  task automatic push_draw();
    stim_step_t s;
    s = '0;
    s.act = ACT_WORD;
    s.word.kind = KIND_DRAW;
    s.word.load_index = ADDR_W'($urandom);
    s.word.load_color = COLOR_W'($urandom);
    s.word.load_alpha = ALPHA_W'($urandom);
    stim_q.push_back(s);
    planned_words++;
  endtask

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return ALPHA_W'($urandom_range(0, 7));
      1: return ALPHA_MIN_VISIBLE;
      2: return ALPHA_MIN_OPAQUE - 1;
      3: return ALPHA_MIN_OPAQUE;
      4: return ALPHA_FULL;
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  // load every entry the current source size can sample that was never written
  task automatic fill_source();
    for (int unsigned i = 0; i < plan_sw * plan_sh; i++)
      if (!loaded_map[i]) push_load(i, COLOR_W'($urandom), pick_alpha());
  endtask

  function automatic logic [SRC_W-1:0] pick_src_side();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SRC_W'($urandom_range(1, 8));
    if (r < 80) return SRC_W'($urandom_range(9, 63));
    if (r < 88) return SRC_W'(MAX_SRC_SIDE);
    if (r < 94) return '0;
    return SRC_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [BOX_W-1:0] pick_box_side();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return BOX_W'($urandom_range(1, 24));
    if (r < 70) return BOX_W'($urandom_range(25, 200));
    if (r < 80) return BOX_W'($urandom_range(201, 1022));
    if (r < 92) return BOX_W'(MAX_BOX_SIDE);
    return '0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    if ($urandom_range(0, 99) >= 15) return CFG_DATA_W'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  initial begin
    int unsigned directed_words, rand_words, n, r;
    logic [CFG_DATA_W-1:0] val;
    logic [6:0] pace_now, pace_want;

    // defaults after reset: 1x1 source, 1x1 box, alpha ignored
    pace_now = 7'd13;
    push_pace(pace_now);
    push_load(0, 16'hFFFF, '0);
    push_draw();
    push_draw();

    // 2x2 source into a tall box, origins at both extremes, the y coordinates wrapping
    push_cfg(CFG_SRC_WIDTH, 16'd2);
    push_cfg(CFG_SRC_HEIGHT, 16'd2);
    push_cfg(CFG_BOX_WIDTH, 16'd3);
    push_cfg(CFG_BOX_HEIGHT, 16'd5);
    push_cfg(CFG_ORIGIN_X, 16'h8000);
    push_cfg(CFG_ORIGIN_Y, 16'h7FFF);
    push_cfg(CFG_ALPHA_PRES, 16'd1);
    push_load(0, 16'h0000, ALPHA_MIN_VISIBLE - 1);
    push_load(1, 16'hFFFF, ALPHA_MIN_VISIBLE);
    push_load(2, 16'hA5A5, ALPHA_MIN_OPAQUE - 1);
    push_load(3, 16'h5A5A, ALPHA_MIN_OPAQUE);
    push_load(STORE_DEPTH - 1, 16'hFFFF, ALPHA_FULL);
    repeat (10) push_draw();

    // write past the register list: restart the walk and redo the fit, no register changes
    push_cfg(CFG_IDX_UNUSED, 16'hFFFF);
    repeat (2) push_draw();

    // zero and oversized source sides, a box squeezing the copy to one pixel
    push_cfg(CFG_SRC_WIDTH, 16'hFF80);
    push_cfg(CFG_SRC_HEIGHT, 16'd127);
    push_cfg(CFG_BOX_WIDTH, 16'd1023);
    push_cfg(CFG_BOX_HEIGHT, 16'd1);
    fill_source();
    repeat (2) push_draw();
    push_cfg(CFG_BOX_WIDTH, 16'hFC00);
    push_cfg(CFG_BOX_HEIGHT, 16'd1023);
    push_cfg(CFG_ALPHA_PRES, 16'hFFFE);
    repeat (3) push_draw();
    directed_words = planned_words;

    rand_words = 0;
    while (rand_words < ITEM_TARGET) begin
      if (rand_words < ITEM_TARGET / 3) pace_want = 7'd13;
      else if (rand_words < 2 * ITEM_TARGET / 3) pace_want = 7'd79;
      else pace_want = 7'd0;
      if (pace_want != pace_now) begin
        pace_now = pace_want;
        push_pace(pace_now);
      end
      val = CFG_DATA_W'($urandom);
      val[SRC_W-1:0] = pick_src_side();
      push_cfg(CFG_SRC_WIDTH, val);
      val = CFG_DATA_W'($urandom);
      val[SRC_W-1:0] = pick_src_side();
      if (plan_sw * side_limit(val[SRC_W-1:0], MAX_SRC_SIDE) > SRC_AREA_CAP)
        val[SRC_W-1:0] = SRC_W'(SRC_AREA_CAP / plan_sw);
      push_cfg(CFG_SRC_HEIGHT, val);
      val = CFG_DATA_W'($urandom);
      val[BOX_W-1:0] = pick_box_side();
      push_cfg(CFG_BOX_WIDTH, val);
      val = CFG_DATA_W'($urandom);
      val[BOX_W-1:0] = pick_box_side();
      push_cfg(CFG_BOX_HEIGHT, val);
      push_cfg(CFG_ORIGIN_X, pick_origin());
      push_cfg(CFG_ORIGIN_Y, pick_origin());
      push_cfg(CFG_ALPHA_PRES, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 9) == 0) push_cfg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
      fill_source();
      n = $urandom_range(15, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 75)
          push_draw();
        else if (r < 90)
          push_load($urandom_range(0, plan_sw * plan_sh - 1), COLOR_W'($urandom), pick_alpha());
        else
          push_load($urandom_range(0, STORE_DEPTH - 1), COLOR_W'($urandom), pick_alpha());
      end
      rand_words = planned_words - directed_words;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() != 0 || start || cfg_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS image_aspect_fit_scaler");
    end else begin
      $display("FAIL image_aspect_fit_scaler");
    end
    $finish;
  end

endmodule
